### src/vszd_pkg.sv
// ----------------------------------------------------------------------------
// vszd_pkg
// shared types and codes for the variable-length size prefix decoder
// ----------------------------------------------------------------------------
package vszd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned LeftW  = 3;
  localparam int unsigned PosW   = 2;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_INVALID   = 2'd1,
    STATUS_TRUNCATED = 2'd2,
    STATUS_END       = 2'd3
  } status_t;

  // one input transfer
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             stream_end;
  } item_t;

  // one result transfer
  typedef struct packed {
    logic [SizeW-1:0] size_value;
    status_t          status;
  } result_t;

endpackage

### src/vszd_in_stage.sv
// ----------------------------------------------------------------------------
// vszd_in_stage
// input register: holds one stream transfer until the core takes it
// ----------------------------------------------------------------------------
module vszd_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  vszd_pkg::item_t in_item,
  input  logic            take,
  output logic            in_stall,
  output logic            held_valid,
  output vszd_pkg::item_t held_item
);

  logic load;

  // a free slot, or one emptied this cycle, takes the next transfer
  assign in_stall = held_valid & ~take;
  assign load     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= in_item;
    end
  end

endmodule

### src/vszd_core.sv
// ----------------------------------------------------------------------------
// vszd_core
// prefix state and the one-byte decode step
// ----------------------------------------------------------------------------
module vszd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  vszd_pkg::item_t   item,
  output logic              res_valid,
  output vszd_pkg::result_t res
);

  logic [vszd_pkg::LeftW-1:0] bytes_left, bytes_left_next;
  logic                       le_form, le_form_next;
  logic [vszd_pkg::PosW-1:0]  byte_pos, byte_pos_next;
  logic [vszd_pkg::SizeW-1:0] acc, acc_next;

  logic [vszd_pkg::ByteW-1:0] b;
  logic [vszd_pkg::SizeW-1:0] le_word;
  logic [vszd_pkg::LeftW-1:0] left_dec;
  logic                       done;

  assign b        = item.data_byte;
  assign le_word  = {{(vszd_pkg::SizeW-vszd_pkg::ByteW){1'b0}}, b} << {byte_pos, 3'b000};
  assign left_dec = bytes_left - 3'd1;

  always_comb begin
    bytes_left_next = bytes_left;
    le_form_next    = le_form;
    byte_pos_next   = byte_pos;
    acc_next        = acc;
    done            = 1'b0;
    res.size_value  = '0;
    res.status      = vszd_pkg::STATUS_OK;

    if (item.stream_end) begin
      done       = 1'b1;
      res.status = (bytes_left == '0) ? vszd_pkg::STATUS_END : vszd_pkg::STATUS_TRUNCATED;
    end else if (bytes_left == '0) begin
      if (b[7]) begin
        // one-byte form or invalid marker
        done = 1'b1;
        if (b[6]) begin
          res.status = vszd_pkg::STATUS_INVALID;
        end else begin
          res.size_value = {{(vszd_pkg::SizeW-7){1'b0}}, b[6:0]};
        end
      end else begin
        le_form_next  = 1'b0;
        byte_pos_next = '0;
        if (b[6]) begin
          acc_next        = {{(vszd_pkg::SizeW-6){1'b0}}, b[5:0]};
          bytes_left_next = 3'd1;
        end else if (b[5]) begin
          acc_next        = {{(vszd_pkg::SizeW-5){1'b0}}, b[4:0]};
          bytes_left_next = 3'd2;
        end else if (b[4]) begin
          acc_next        = {{(vszd_pkg::SizeW-4){1'b0}}, b[3:0]};
          bytes_left_next = 3'd3;
        end else begin
          acc_next        = '0;
          le_form_next    = 1'b1;
          bytes_left_next = 3'd4;
        end
      end
    end else begin
      if (le_form) begin
        acc_next      = acc | le_word;
        byte_pos_next = byte_pos + 2'd1;
      end else begin
        acc_next = {acc[vszd_pkg::SizeW-vszd_pkg::ByteW-1:0], b};
      end
      bytes_left_next = left_dec;
      if (left_dec == '0) begin
        done           = 1'b1;
        res.size_value = acc_next;
      end
    end

    // every result sends the decoder back to idle
    if (done) begin
      bytes_left_next = '0;
      le_form_next    = 1'b0;
      byte_pos_next   = '0;
      acc_next        = '0;
    end
  end

  assign res_valid = step & done;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      le_form    <= 1'b0;
      byte_pos   <= '0;
      acc        <= '0;
    end else if (step) begin
      bytes_left <= bytes_left_next;
      le_form    <= le_form_next;
      byte_pos   <= byte_pos_next;
      acc        <= acc_next;
    end
  end

endmodule

### src/vszd_out_stage.sv
// ----------------------------------------------------------------------------
// vszd_out_stage
// result register toward the consumer
// ----------------------------------------------------------------------------
module vszd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  vszd_pkg::result_t res,
  input  logic              out_stall,
  output logic              out_valid,
  output vszd_pkg::result_t out_res,
  output logic              room
);

  // the slot is free when empty or when its transfer completes this cycle
  assign room = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room & res_valid) begin
      out_res <= res;
    end
  end

endmodule

### src/varlen_size_prefix_decoder.sv
// ----------------------------------------------------------------------------
// varlen_size_prefix_decoder
// decodes variable-length size prefixes from a byte stream
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------
//   input   | in_valid / in_stall  | data_byte[7:0], stream_end
//   output  | out_valid / out_stall| size_value[31:0], status[1:0]
//
// one transfer per cycle sustained on both sides while the output is not stalled
// a byte is held in the input register; its result is then registered in the
// result register on its way to the output
// the decode step is one shift-or into the accumulator plus a counter update
// rst (synchronous, active high) clears both valid flags and the prefix state
// a stalled output holds the result and backs up into the input register;
// in_stall rises only while both registers are full and the output is stalled
//
module varlen_size_prefix_decoder (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        stream_end,
  // result stream
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] size_value,
  output logic [1:0]  status
);

  vszd_pkg::item_t   in_item;
  vszd_pkg::item_t   held_item;
  vszd_pkg::result_t core_res;
  vszd_pkg::result_t out_res;
  logic              held_valid;
  logic              core_res_valid;
  logic              room;
  logic              step;

  assign in_item.data_byte  = data_byte;
  assign in_item.stream_end = stream_end;

  // the held transfer is decoded whenever the result slot can take it
  assign step = held_valid & room;

  vszd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .take       (step),
    .in_stall   (in_stall),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  vszd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (held_item),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  vszd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (core_res_valid),
    .res       (core_res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .room      (room)
  );

  assign size_value = out_res.size_value;
  assign status     = out_res.status;

endmodule

### tb/varlen_size_prefix_decoder_tb.sv
// ----------------------------------------------------------------------------
// varlen_size_prefix_decoder_tb
// self-checking bench for the size prefix decoder: a queue-fed driver offers
// directed and random byte streams with random gaps, a predictor tracks the
// prefix state per accepted transfer, and the monitor checks every result
// against the oldest predicted one while the receiver stalls at random
// ----------------------------------------------------------------------------
module varlen_size_prefix_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one queued input transfer plus the idle cycles before it is offered
  typedef struct {
    logic [vszd_pkg::ByteW-1:0] data_byte;
    logic                       stream_end;
    int unsigned                gap;
  } stream_byte_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       data_byte = '0;
  logic             stream_end = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [31:0]      size_value;
  logic [1:0]       status;

  varlen_size_prefix_decoder dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .size_value (size_value),
    .status     (status)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // pending stream bytes and predicted results
  stream_byte_t        stim_q[$];
  vszd_pkg::result_t   pending_sizes[$];
  int                  stim_total;
  int                  fails = 0;

  // transfer counters, each written by one process only
  int           in_sent_cnt = 0;   // transfers put on the input bus (driver)
  int           in_acc_cnt = 0;    // input transfers taken (monitor)
  int           res_cnt = 0;       // result transfers taken (monitor)

  // predictor copy of the prefix state
  logic [vszd_pkg::LeftW-1:0] pfx_left = '0;
  logic                       pfx_le = 1'b0;
  logic [vszd_pkg::PosW-1:0]  pfx_pos = '0;
  logic [vszd_pkg::SizeW-1:0] pfx_acc = '0;

  // stimulus helpers
  logic             quiet_in = 1'b0;

  // queue one input transfer; the gap is zero during quiet stretches
  task automatic push_byte(input logic [7:0] b, input logic e);
    stream_byte_t s;
    s.data_byte  = b;
    s.stream_end = e;
    s.gap        = quiet_in ? 0 : $urandom_range(0, 14);
    stim_q.push_back(s);
  endtask

  // random byte leaning toward all-zero and all-one now and then
  function automatic logic [7:0] rand_byte();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // one random prefix: mostly well formed, some cut short, some invalid or
  // bare end-of-stream transfers
  task automatic push_random_prefix();
    int unsigned kind;
    int unsigned form;
    int unsigned len;
    int unsigned cut;
    logic [7:0]  lead;
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      push_byte(8'($urandom), 1'b1);
    end else if (kind < 10) begin
      push_byte({2'b11, 6'($urandom)}, 1'b0);
    end else begin
      form = $urandom_range(0, 4);
      case (form)
        0: begin lead = {2'b10, 6'($urandom)};   len = 1; end
        1: begin lead = {2'b01, 6'($urandom)};   len = 2; end
        2: begin lead = {3'b001, 5'($urandom)};  len = 3; end
        3: begin lead = {4'b0001, 4'($urandom)}; len = 4; end
        default: begin lead = {4'b0000, 4'($urandom)}; len = 5; end
      endcase
      // truncated prefix: end-of-stream arrives after cut bytes
      cut = len;
      if (kind < 22 && len > 1) cut = $urandom_range(1, len - 1);
      push_byte(lead, 1'b0);
      for (int i = 1; i < cut; i++) push_byte(rand_byte(), 1'b0);
      if (cut < len) push_byte(8'($urandom), 1'b1);
    end
  endtask

  // advance the predicted prefix state by one accepted transfer
  task automatic decode_prefix_byte(input logic [7:0] b, input logic e);
    vszd_pkg::result_t r;
    logic              done;
    done         = 1'b0;
    r.size_value = '0;
    r.status     = vszd_pkg::STATUS_OK;
    if (e) begin
      // end of stream: clean when idle, truncation mid-prefix
      done     = 1'b1;
      r.status = (pfx_left == 0) ? vszd_pkg::STATUS_END : vszd_pkg::STATUS_TRUNCATED;
    end else if (pfx_left == 0) begin
      if (b[7]) begin
        done = 1'b1;
        if (b[6]) r.status = vszd_pkg::STATUS_INVALID;
        else r.size_value = {26'd0, b[5:0]};
      end else begin
        pfx_le  = 1'b0;
        pfx_pos = '0;
        if (b[6]) begin
          pfx_acc  = {26'd0, b[5:0]};
          pfx_left = 3'd1;
        end else if (b[5]) begin
          pfx_acc  = {27'd0, b[4:0]};
          pfx_left = 3'd2;
        end else if (b[4]) begin
          pfx_acc  = {28'd0, b[3:0]};
          pfx_left = 3'd3;
        end else begin
          // little-endian form, low nibble of the lead byte is dropped
          pfx_acc  = '0;
          pfx_le   = 1'b1;
          pfx_left = 3'd4;
        end
      end
    end else begin
      if (pfx_le) begin
        pfx_acc = pfx_acc | ({24'd0, b} << (8 * pfx_pos));
        pfx_pos = pfx_pos + 1'b1;
      end else begin
        pfx_acc = {pfx_acc[23:0], b};
      end
      pfx_left = pfx_left - 1'b1;
      if (pfx_left == 0) begin
        done         = 1'b1;
        r.size_value = pfx_acc;
      end
    end
    if (done) begin
      pending_sizes.push_back(r);
      pfx_left = '0;
      pfx_le   = 1'b0;
      pfx_pos  = '0;
      pfx_acc  = '0;
    end
  endtask

  // input driver: changes only at the falling edge, holds a stalled payload
  stream_byte_t cur_byte;
  int unsigned  gap_left = 0;
  logic         gap_armed = 1'b0;

  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_acc_cnt < in_sent_cnt) begin
        // transfer still pending, keep everything as it is
      end else begin
        if (!gap_armed && stim_q.size() > 0) begin
          gap_left  = stim_q[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_armed && gap_left == 0) begin
          cur_byte   = stim_q.pop_front();
          in_valid   <= 1'b1;
          data_byte  <= cur_byte.data_byte;
          stream_end <= cur_byte.stream_end;
          in_sent_cnt++;
          gap_armed  = 1'b0;
        end else begin
          if (gap_armed) gap_left--;
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: a fresh hold-off per result, quiet stretches, and one long
  // hold so the result register backs up into the input side
  int   seen_res = 0;
  int   out_hold_left = 0;
  logic quiet_out = 1'b0;
  logic long_hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst) begin
      if (seen_res != res_cnt) begin
        seen_res = res_cnt;
        if ($urandom_range(0, 29) == 0) quiet_out = !quiet_out;
        out_hold_left = quiet_out ? 0 : $urandom_range(0, 14);
        if (res_cnt >= 60 && !long_hold_done) begin
          out_hold_left  = 300;
          long_hold_done = 1'b1;
        end
      end
      if (out_hold_left > 0) begin
        out_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: sample both channels at the rising edge
  vszd_pkg::result_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        res_cnt++;
        if (pending_sizes.size() == 0) begin
          $error("result with nothing pending: size_value %0h status %0d",
                 size_value, status);
          fails++;
        end else begin
          want = pending_sizes.pop_front();
          if (size_value !== want.size_value) begin
            $error("size_value mismatch: expected %0h, actual %0h",
                   want.size_value, size_value);
            fails++;
          end
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d",
                   want.status, status);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_acc_cnt++;
        decode_prefix_byte(data_byte, stream_end);
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    // directed: end while idle with a junk byte, one-byte extremes,
    // invalid leads, every big-endian form at its top value, the
    // little-endian form at its top value and with distinct bytes,
    // then a prefix cut short by end-of-stream
    push_byte(8'hFF, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hC0, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h3F, 1'b0);
    repeat (2) push_byte(8'hFF, 1'b0);
    push_byte(8'h1F, 1'b0);
    repeat (3) push_byte(8'hFF, 1'b0);
    push_byte(8'h0F, 1'b0);
    repeat (4) push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    for (int i = 1; i <= 4; i++) push_byte(8'(i), 1'b0);
    push_byte(8'h40, 1'b0);
    push_byte(8'h00, 1'b1);

    // random stretch, quiet sender spells now and then
    while (stim_q.size() < 950) begin
      if ($urandom_range(0, 19) == 0) quiet_in = !quiet_in;
      push_random_prefix();
    end
    stim_total = stim_q.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (in_acc_cnt == stim_total);
    wait (pending_sizes.size() == 0);
    // leave room for any stray result
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
